FILE: hw/rtl/fprf_pkg.sv
// ----------------------------------------------------------------------------
// fprf_pkg
// shared types, codes and defaults of the footprint point reject filter
// ----------------------------------------------------------------------------
package fprf_pkg;

  localparam int MAX_VERTICES_DEF  = 16;
  localparam int COORD_BITS_DEF    = 16;
  localparam int MIN_POLY_VERTICES = 3;

  localparam int RADIUS_W   = 15;
  localparam int COUNT_W    = 5;
  localparam int INDEX_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [RADIUS_W-1:0] RADIUS_RST       = 15'd512;
  localparam logic [COUNT_W-1:0]  VERTEX_COUNT_RST = 5'd0;
  localparam logic                CIRC_MODE_RST    = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CIRCULAR_MODE = 2'd0,
    CFG_RADIUS        = 2'd1,
    CFG_VERTEX_COUNT  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    KIND_POINT  = 1'b0,
    KIND_VERTEX = 1'b1
  } kind_t;

  // control that travels with a point down the pipeline
  typedef struct packed {
    logic valid;
    logic drop;
  } tok_ctrl_t;

endpackage

FILE: hw/rtl/footprint_point_reject_filter.sv
// ----------------------------------------------------------------------------
// footprint_point_reject_filter
// drops point-cloud points inside the robot footprint, passes the rest
// ----------------------------------------------------------------------------
// usage
//   in_*  : one word per point (kind point) or per vertex load (kind vertex)
//   out_* : one word per kept point, x/y/z unchanged
//   cfg_* : register writes (circular_mode, radius, vertex_count), always
//           ready, to be written only while the filter is idle
// timing
//   points enter one per cycle while out_stall does not hold the chain; a point
//   passes two circle stages, three stages per vertex cell and the output
//   register
//   a vertex load waits in in_stall until every point in flight has left the
//   cell chain, then is written into its cell; it gives no output word
// reset
//   clears the pipeline valid flags and out_valid, loads circular mode with a
//   0.5 m radius and no vertices; vertex slots hold nothing until loaded
// stall
//   out_stall with out_valid high freezes the whole chain and holds the output
//   word; in_stall goes high in the same cycle
// ----------------------------------------------------------------------------
module footprint_point_reject_filter import fprf_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // point / vertex words
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_kind,
  input  logic [INDEX_W-1:0]           in_vertex_index,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic signed [COORD_BITS-1:0] in_point_z,
  // kept points
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z,
  // register writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  localparam int IDX_W      = $clog2(MAX_VERTICES);
  localparam int NCW        = $clog2(MAX_VERTICES + 1);
  localparam int NW         = (NCW > COUNT_W) ? NCW : COUNT_W;
  localparam int FLIGHT_MAX = 3 * MAX_VERTICES + 2;
  localparam int FW         = $clog2(FLIGHT_MAX + 1);

  // configuration registers
  logic                circular_mode_r;
  logic [RADIUS_W-1:0] radius_r;
  logic [COUNT_W-1:0]  vertex_count_r;

  // handshake and flow control
  logic          adv;
  logic          pt_acc;
  logic          vtx_acc;
  logic          leave;
  logic [FW-1:0] inflight_r;
  logic [FW-1:0] inflight_nxt;

  // polygon control
  logic [NW-1:0]    vc_ext;
  logic [NW-1:0]    n_sat;
  logic             poly_en;
  logic [IDX_W-1:0] last_idx;

  // chain of tokens, slot 0 is the circle stage output
  tok_ctrl_t                    head_ctrl;
  tok_ctrl_t                    ch_ctrl [0:MAX_VERTICES];
  logic signed [COORD_BITS-1:0] ch_x    [0:MAX_VERTICES];
  logic signed [COORD_BITS-1:0] ch_y    [0:MAX_VERTICES];
  logic signed [COORD_BITS-1:0] ch_z    [0:MAX_VERTICES];
  logic signed [COORD_BITS-1:0] vx_all  [0:MAX_VERTICES-1];
  logic signed [COORD_BITS-1:0] vy_all  [0:MAX_VERTICES-1];

  // output word
  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] out_x_r;
  logic signed [COORD_BITS-1:0] out_y_r;
  logic signed [COORD_BITS-1:0] out_z_r;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      circular_mode_r <= CIRC_MODE_RST;
      radius_r        <= RADIUS_RST;
      vertex_count_r  <= VERTEX_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CIRCULAR_MODE: circular_mode_r <= cfg_data[0];
        CFG_RADIUS:        radius_r        <= cfg_data[RADIUS_W-1:0];
        CFG_VERTEX_COUNT:  vertex_count_r  <= cfg_data[COUNT_W-1:0];
        default: ;  // write beyond the register list is dropped
      endcase
    end
  end

  // vertex count clamps to the number of cells
  assign vc_ext   = NW'(vertex_count_r);
  assign n_sat    = (vc_ext > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : vc_ext;
  assign poly_en  = !circular_mode_r && (n_sat >= NW'(MIN_POLY_VERTICES));
  // only meaningful when poly_en is set, then n_sat is at least three
  assign last_idx = IDX_W'(n_sat - NW'(1));

  // ---------------------------------------------------------- flow control
  // the whole chain moves together unless the output word is held
  assign adv      = !out_valid_r || !out_stall;
  // a vertex load must not change a vertex that a point still has to see
  assign in_stall = !adv || ((in_kind == KIND_VERTEX) && (inflight_r != '0));
  assign pt_acc   = in_valid && !in_stall && (in_kind == KIND_POINT);
  assign vtx_acc  = in_valid && !in_stall && (in_kind == KIND_VERTEX);
  assign leave    = adv && ch_ctrl[MAX_VERTICES].valid;

  // points between the input and the output register
  assign inflight_nxt = inflight_r + FW'(pt_acc) - FW'(leave);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // ---------------------------------------------------------- circle stage
  assign head_ctrl = '{valid: pt_acc, drop: 1'b0};

  fprf_circle #(
    .COORD_BITS (COORD_BITS)
  ) u_circle (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .circular_mode (circular_mode_r),
    .radius        (radius_r),
    .in_ctrl       (head_ctrl),
    .in_x          (in_point_x),
    .in_y          (in_point_y),
    .in_z          (in_point_z),
    .out_ctrl      (ch_ctrl[0]),
    .out_x         (ch_x[0]),
    .out_y         (ch_y[0]),
    .out_z         (ch_z[0])
  );

  // ------------------------------------------------------------ cell chain
  // cell k owns vertex k and tests the edge to vertex k-1; cell 0 closes
  // the polygon with the last vertex in use
  for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
    logic                         cell_en;
    logic                         wr_en;
    logic signed [COORD_BITS-1:0] prev_x;
    logic signed [COORD_BITS-1:0] prev_y;

    assign cell_en = poly_en && (NW'(k) < n_sat);

    if (k < (1 << INDEX_W)) begin : g_wr
      assign wr_en = vtx_acc && (in_vertex_index == INDEX_W'(k));
    end else begin : g_nowr
      // slots the index field cannot reach are never loaded
      assign wr_en = 1'b0;
    end

    if (k == 0) begin : g_first
      assign prev_x = vx_all[last_idx];
      assign prev_y = vy_all[last_idx];
    end else begin : g_next
      assign prev_x = vx_all[k-1];
      assign prev_y = vy_all[k-1];
    end

    fprf_cell #(
      .COORD_BITS (COORD_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cell_en  (cell_en),
      .wr_en    (wr_en),
      .wr_x     (in_point_x),
      .wr_y     (in_point_y),
      .prev_x   (prev_x),
      .prev_y   (prev_y),
      .vx       (vx_all[k]),
      .vy       (vy_all[k]),
      .in_ctrl  (ch_ctrl[k]),
      .in_x     (ch_x[k]),
      .in_y     (ch_y[k]),
      .in_z     (ch_z[k]),
      .out_ctrl (ch_ctrl[k+1]),
      .out_x    (ch_x[k+1]),
      .out_y    (ch_y[k+1]),
      .out_z    (ch_z[k+1])
    );
  end

  // ----------------------------------------------------------- output word
  // drop flag is the circle result or the ray-cast parity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ch_ctrl[MAX_VERTICES].valid && !ch_ctrl[MAX_VERTICES].drop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ch_ctrl[MAX_VERTICES].valid) begin
      out_x_r <= ch_x[MAX_VERTICES];
      out_y_r <= ch_y[MAX_VERTICES];
      out_z_r <= ch_z[MAX_VERTICES];
    end
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;

`ifndef SYNTHESIS
  // an empty in-flight count means no point is at the chain end
  a_empty_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (inflight_r == '0) |-> !ch_ctrl[MAX_VERTICES].valid)
    else $error("point at chain end while nothing is in flight");

  // a held output word freezes the chain, seen as a stable in-flight count
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(inflight_r))
    else $error("chain moved while output word was held");

  // a rise of out_valid only comes from a kept point at the chain end
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      $past(ch_ctrl[MAX_VERTICES].valid && !ch_ctrl[MAX_VERTICES].drop))
    else $error("output word without a kept point");
`endif

endmodule

FILE: hw/rtl/fprf_circle.sv
// ----------------------------------------------------------------------------
// fprf_circle
// two-stage circle test at the head of the pipeline, seeds the drop flag
// ----------------------------------------------------------------------------
module fprf_circle import fprf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         circular_mode,
  input  logic [RADIUS_W-1:0]          radius,
  input  tok_ctrl_t                    in_ctrl,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic signed [COORD_BITS-1:0] in_z,
  output tok_ctrl_t                    out_ctrl,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z
);

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int RSQ_W = 2 * RADIUS_W;
  localparam int SUM_W = SQ_W + 1;
  localparam int CMP_W = (SUM_W > RSQ_W) ? SUM_W : RSQ_W;

  logic [COORD_BITS-1:0] mag_x;
  logic [COORD_BITS-1:0] mag_y;
  logic [CMP_W-1:0]      sum_sq;
  logic                  in_circle;

  logic                         a_valid_r;
  logic [SQ_W-1:0]              a_sqx_r;
  logic [SQ_W-1:0]              a_sqy_r;
  logic signed [COORD_BITS-1:0] a_x_r;
  logic signed [COORD_BITS-1:0] a_y_r;
  logic signed [COORD_BITS-1:0] a_z_r;
  logic [RSQ_W-1:0]             rsq_r;

  tok_ctrl_t                    b_ctrl_r;
  logic signed [COORD_BITS-1:0] b_x_r;
  logic signed [COORD_BITS-1:0] b_y_r;
  logic signed [COORD_BITS-1:0] b_z_r;

  assign mag_x = in_x[COORD_BITS-1] ? COORD_BITS'(-in_x) : COORD_BITS'(in_x);
  assign mag_y = in_y[COORD_BITS-1] ? COORD_BITS'(-in_y) : COORD_BITS'(in_y);

  assign sum_sq    = CMP_W'(a_sqx_r) + CMP_W'(a_sqy_r);
  assign in_circle = sum_sq <= CMP_W'(rsq_r);

  // radius squared follows the register in the next cycle
  always_ff @(posedge clk) begin
    rsq_r <= radius * radius;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_ctrl_r  <= '0;
    end else if (adv) begin
      a_valid_r      <= in_ctrl.valid;
      b_ctrl_r.valid <= a_valid_r;
      b_ctrl_r.drop  <= circular_mode & in_circle;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sqx_r <= mag_x * mag_x;
      a_sqy_r <= mag_y * mag_y;
      a_x_r   <= in_x;
      a_y_r   <= in_y;
      a_z_r   <= in_z;
      b_x_r   <= a_x_r;
      b_y_r   <= a_y_r;
      b_z_r   <= a_z_r;
    end
  end

  assign out_ctrl = b_ctrl_r;
  assign out_x    = b_x_r;
  assign out_y    = b_y_r;
  assign out_z    = b_z_r;

endmodule

FILE: hw/rtl/fprf_cell.sv
// ----------------------------------------------------------------------------
// fprf_cell
// one polygon vertex: holds it and tests the edge to the previous vertex
// ----------------------------------------------------------------------------
module fprf_cell import fprf_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         cell_en,
  input  logic                         wr_en,
  input  logic signed [COORD_BITS-1:0] wr_x,
  input  logic signed [COORD_BITS-1:0] wr_y,
  input  logic signed [COORD_BITS-1:0] prev_x,
  input  logic signed [COORD_BITS-1:0] prev_y,
  output logic signed [COORD_BITS-1:0] vx,
  output logic signed [COORD_BITS-1:0] vy,
  input  tok_ctrl_t                    in_ctrl,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic signed [COORD_BITS-1:0] in_z,
  output tok_ctrl_t                    out_ctrl,
  output logic signed [COORD_BITS-1:0] out_x,
  output logic signed [COORD_BITS-1:0] out_y,
  output logic signed [COORD_BITS-1:0] out_z
);

  localparam int D_W = COORD_BITS + 1;
  localparam int P_W = 2 * D_W;

  logic signed [COORD_BITS-1:0] vx_r;
  logic signed [COORD_BITS-1:0] vy_r;

  logic signed [D_W-1:0] dif_a;
  logic signed [D_W-1:0] dif_b;
  logic signed [D_W-1:0] dif_c;
  logic signed [D_W-1:0] dif_dy;
  logic                  straddle;
  logic                  flip;

  tok_ctrl_t                    s1_ctrl_r;
  logic signed [COORD_BITS-1:0] s1_x_r;
  logic signed [COORD_BITS-1:0] s1_y_r;
  logic signed [COORD_BITS-1:0] s1_z_r;
  logic signed [D_W-1:0]        s1_a_r;
  logic signed [D_W-1:0]        s1_b_r;
  logic signed [D_W-1:0]        s1_c_r;
  logic signed [D_W-1:0]        s1_dy_r;
  logic                         s1_hit_r;

  tok_ctrl_t                    s2_ctrl_r;
  logic signed [COORD_BITS-1:0] s2_x_r;
  logic signed [COORD_BITS-1:0] s2_y_r;
  logic signed [COORD_BITS-1:0] s2_z_r;
  logic signed [P_W-1:0]        s2_p1_r;
  logic signed [P_W-1:0]        s2_p2_r;
  logic                         s2_dyneg_r;
  logic                         s2_hit_r;

  tok_ctrl_t                    s3_ctrl_r;
  logic signed [COORD_BITS-1:0] s3_x_r;
  logic signed [COORD_BITS-1:0] s3_y_r;
  logic signed [COORD_BITS-1:0] s3_z_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vx_r <= wr_x;
      vy_r <= wr_y;
    end
  end

  // edge from this vertex (i) to the previous one (j)
  assign dif_a    = D_W'(in_x) - D_W'(vx_r);
  assign dif_b    = D_W'(prev_x) - D_W'(vx_r);
  assign dif_c    = D_W'(in_y) - D_W'(vy_r);
  assign dif_dy   = D_W'(prev_y) - D_W'(vy_r);
  assign straddle = (vy_r > in_y) != (prev_y > in_y);

  // dy is never zero on a straddling edge
  assign flip = s2_hit_r && (s2_dyneg_r ? (s2_p1_r > s2_p2_r) : (s2_p1_r < s2_p2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctrl_r <= '0;
      s2_ctrl_r <= '0;
      s3_ctrl_r <= '0;
    end else if (adv) begin
      s1_ctrl_r       <= in_ctrl;
      s2_ctrl_r       <= s1_ctrl_r;
      s3_ctrl_r.valid <= s2_ctrl_r.valid;
      s3_ctrl_r.drop  <= s2_ctrl_r.drop ^ flip;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x_r     <= in_x;
      s1_y_r     <= in_y;
      s1_z_r     <= in_z;
      s1_a_r     <= dif_a;
      s1_b_r     <= dif_b;
      s1_c_r     <= dif_c;
      s1_dy_r    <= dif_dy;
      s1_hit_r   <= straddle & cell_en;
      s2_x_r     <= s1_x_r;
      s2_y_r     <= s1_y_r;
      s2_z_r     <= s1_z_r;
      s2_p1_r    <= s1_a_r * s1_dy_r;
      s2_p2_r    <= s1_b_r * s1_c_r;
      s2_dyneg_r <= s1_dy_r[D_W-1];
      s2_hit_r   <= s1_hit_r;
      s3_x_r     <= s2_x_r;
      s3_y_r     <= s2_y_r;
      s3_z_r     <= s2_z_r;
    end
  end

  assign vx       = vx_r;
  assign vy       = vy_r;
  assign out_ctrl = s3_ctrl_r;
  assign out_x    = s3_x_r;
  assign out_y    = s3_y_r;
  assign out_z    = s3_z_r;

endmodule
